@@ rtl/mrtm_pkg.sv @@
// ----------------------------------------------------------------------------
// mrtm_pkg
// Shared types and constants of the rate controller and rotor mixer.
// ----------------------------------------------------------------------------
package mrtm_pkg;

  localparam int MAX_ROTORS   = 6;
  localparam int NUM_ROTORS_D = 6;

  localparam int FIELD_W   = 16;
  localparam int S_DATA_W  = 112;
  localparam int M_DATA_W  = 96;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int GAINS_W   = 48;

  localparam int VEC_W  = 34;
  localparam int MULB_W = 17;
  localparam int PROD_W = VEC_W + MULB_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC_SH = 30;
  localparam int SQ_W   = 32;
  localparam int ROOT_W = 16;
  localparam int ROT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAINS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_0  = 3'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GMUL,
    S_GACC,
    S_MMUL,
    S_MACC,
    S_SAT,
    S_ROOT,
    S_OUT
  } mrtm_state_t;

endpackage

@@ rtl/mrtm_isqrt.sv @@
// ----------------------------------------------------------------------------
// mrtm_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mrtm_isqrt
  import mrtm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [SQ_W-1:0]   x;
  logic [ROOT_W+1:0] rem;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              fits;

  assign rem_sh = {rem[ROOT_W:0], x[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x <= x << 2;
      if (fits) begin
        rem  <= diff[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/multirotor_rate_thrust_mixer.sv @@
// ----------------------------------------------------------------------------
// multirotor_rate_thrust_mixer
// Body-rate P controller with per-rotor mixing and integer square root.
// ----------------------------------------------------------------------------
// Each request carries measured body rates and, when tuser is set, a new rate
// and thrust command that is held for later requests. One signed 34x17
// multiplier is shared by all products: three gain products come first,
// then every rotor takes four multiply-accumulate pairs, a clamp and a
// square root of 16 steps. Before the first command a request returns
// all zero speeds. The input is taken again once the result has moved into
// the output register.
module multirotor_rate_thrust_mixer
  import mrtm_pkg::*;
#(
  parameter int NUM_ROTORS = NUM_ROTORS_D
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // measured_rate_x, measured_rate_y, measured_rate_z, cmd_rate_x,
  // cmd_rate_y, cmd_rate_z, cmd_thrust
  input  logic [S_DATA_W-1:0]  s_tdata,
  // command_present
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // rotor_speed_0 .. rotor_speed_5
  output logic [M_DATA_W-1:0]  m_tdata
);

  localparam int RW = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;

  mrtm_state_t st, st_next;

  logic [GAINS_W-1:0]   gains;
  logic [CFG_DAT_W-1:0] mix_row [NUM_ROTORS];

  logic                 active;
  logic [FIELD_W-1:0]   meas_x, meas_y, meas_z;
  logic [FIELD_W-1:0]   cmd_x, cmd_y, cmd_z, cmd_thrust;

  logic [1:0]           ax;
  logic [ROT_W-1:0]     rot;
  logic signed [VEC_W-1:0]  vec [4];
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0]    speeds [MAX_ROTORS];

  logic                 accept;
  logic                 cmd_now;
  logic                 out_load;
  logic                 root_start;
  logic                 root_done;
  logic [ROOT_W-1:0]    root;
  logic [SQ_W-1:0]      sq;

  logic [FIELD_W-1:0]       sel_meas, sel_cmd, sel_gain, sel_coef;
  logic signed [FIELD_W:0]  err;
  logic signed [VEC_W-1:0]  mul_a;
  logic signed [MULB_W-1:0] mul_b;
  logic [PROD_W-1:0]        acc_neg;

  assign accept  = s_tvalid && s_tready;
  assign cmd_now = s_tuser;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
      for (int i = 0; i < NUM_ROTORS; i++) begin
        mix_row[i] <= '0;
      end
    end else if (cfg_wen) begin
      if (cfg_index == CFG_RATE_GAINS) begin
        gains <= cfg_wdata[GAINS_W-1:0];
      end else if (cfg_index >= CFG_MIX_ROW_0 &&
                   cfg_index < CFG_MIX_ROW_0 + CFG_IDX_W'(NUM_ROTORS)) begin
        mix_row[RW'(cfg_index - CFG_MIX_ROW_0)] <= cfg_wdata;
      end
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ax)
      2'd0: begin
        sel_meas = meas_x;
        sel_cmd  = cmd_x;
        sel_gain = gains[15:0];
      end
      2'd1: begin
        sel_meas = meas_y;
        sel_cmd  = cmd_y;
        sel_gain = gains[31:16];
      end
      default: begin
        sel_meas = meas_z;
        sel_cmd  = cmd_z;
        sel_gain = gains[47:32];
      end
    endcase
    sel_coef = mix_row[rot[RW-1:0]][{ax, 4'd0} +: FIELD_W];
    err = $signed({sel_meas[FIELD_W-1], sel_meas}) - $signed({sel_cmd[FIELD_W-1], sel_cmd});
    if (st == S_GMUL) begin
      mul_a = VEC_W'(err);
      mul_b = $signed({1'b0, sel_gain});
    end else begin
      mul_a = vec[ax];
      mul_b = MULB_W'($signed(sel_coef));
    end
  end

  assign acc_neg = -prod;
  assign sq = (!sum[SUM_W-1] && sum != '0) ? SQ_W'(sum[SUM_W-1:FRAC_SH]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next    = st;
    s_tready   = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (st)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          st_next = (active || cmd_now) ? S_GMUL : S_OUT;
        end
      end
      S_GMUL: st_next = S_GACC;
      S_GACC: st_next = (ax == 2'd2) ? S_MMUL : S_GMUL;
      S_MMUL: st_next = S_MACC;
      S_MACC: st_next = (ax == 2'd3) ? S_SAT : S_MMUL;
      S_SAT: begin
        root_start = 1'b1;
        st_next    = S_ROOT;
      end
      S_ROOT: begin
        if (root_done) begin
          st_next = (rot == ROT_W'(NUM_ROTORS - 1)) ? S_OUT : S_MMUL;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      cmd_x      <= '0;
      cmd_y      <= '0;
      cmd_z      <= '0;
      cmd_thrust <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept && cmd_now) begin
        active     <= 1'b1;
        cmd_x      <= s_tdata[63:48];
        cmd_y      <= s_tdata[79:64];
        cmd_z      <= s_tdata[95:80];
        cmd_thrust <= s_tdata[111:96];
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meas_x <= s_tdata[15:0];
      meas_y <= s_tdata[31:16];
      meas_z <= s_tdata[47:32];
      ax     <= '0;
      rot    <= '0;
      for (int i = 0; i < MAX_ROTORS; i++) begin
        speeds[i] <= '0;
      end
    end
    unique case (st)
      S_GMUL, S_MMUL: prod <= mul_a * mul_b;
      S_GACC: begin
        vec[ax] <= acc_neg[VEC_W-1:0];
        sum     <= '0;
        if (ax == 2'd2) begin
          vec[3] <= {8'd0, cmd_thrust, 10'd0};
          ax     <= '0;
        end else begin
          ax <= ax + 2'd1;
        end
      end
      S_MACC: begin
        sum <= sum + SUM_W'(prod);
        ax  <= ax + 2'd1;
      end
      S_ROOT: begin
        if (root_done) begin
          speeds[rot] <= root;
          sum         <= '0;
          rot         <= rot + 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      for (int i = 0; i < MAX_ROTORS; i++) begin
        m_tdata[i*ROOT_W +: ROOT_W] <= speeds[i];
      end
    end
  end

  mrtm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq),
    .done     (root_done),
    .root     (root)
  );

`ifndef SYNTHESIS
  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    st != S_IDLE |-> rot <= ROT_W'(NUM_ROTORS))
    else $error("rotor counter beyond rotor count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input ready right after a request was taken");

  a_root_done_state: assert property (@(posedge clk) disable iff (rst)
    root_done |-> st == S_ROOT)
    else $error("square root finished outside its state");

  a_out_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("result loaded without valid");
`endif

endmodule

@@ tb/multirotor_rate_thrust_mixer_tb.sv @@
// ----------------------------------------------------------------------------
// multirotor_rate_thrust_mixer_tb
// Self-checking bench for the rate controller and rotor mixer.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver on the slave stream, and a clocked
// monitor checks every rotor speed on the master stream. The expected speeds
// come from a bench-side model that holds its own copy of the gains, the mixing
// rows and the held command. Directed requests cover the inactive start, the
// first command, field extremes and extreme or zero settings. Random phases
// then follow, each with a new register setting; all but the last add random
// idling on both sides. One long output stall backs the block up to its input.
// ----------------------------------------------------------------------------
module multirotor_rate_thrust_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrtm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int PHASE_REQS     = 310;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_STALL     = 900;

  typedef struct packed {
    logic [15:0] cmd_thrust;
    logic [15:0] cmd_z;
    logic [15:0] cmd_y;
    logic [15:0] cmd_x;
    logic        cmd_present;
    logic [15:0] meas_z;
    logic [15:0] meas_y;
    logic [15:0] meas_x;
  } rate_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;

  // Bench copy of the block's registers and state.
  logic [GAINS_W-1:0]   gains_q = '0;
  logic [CFG_DAT_W-1:0] mix_q [MAX_ROTORS];
  logic [63:0]          held_cmd_q = '0;
  logic                 ctrl_active_q = 1'b0;

  logic [GAINS_W-1:0]   next_gains;
  logic [CFG_DAT_W-1:0] next_rows [MAX_ROTORS];

  rate_req_t           pend_reqs [$];
  logic [M_DATA_W-1:0] exp_speeds [$];
  rate_req_t           cur_req;
  rate_req_t           gen_cmd = '0;
  logic [M_DATA_W-1:0] want;

  int  n_pushed = 0;
  int  n_accepted = 0;
  int  errors = 0;
  int  gap_in = 0;
  int  gap_out = 0;
  int  stall_out = 0;
  int  idle_cycles = 0;
  int  k;
  int  ph;
  bit  calm = 1'b0;
  bit  long_stall_done = 1'b0;

  multirotor_rate_thrust_mixer #(
    .NUM_ROTORS(NUM_ROTORS_D)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] int_sqrt(input logic [31:0] x);
    logic [15:0] root;
    logic [31:0] trial;
    int b;
    root = '0;
    for (b = 15; b >= 0; b--) begin
      trial = {16'd0, root | (16'd1 << b)};
      if (trial * trial <= x) root = trial[15:0];
    end
    return root;
  endfunction

  function automatic logic [M_DATA_W-1:0] predict_speeds(input rate_req_t r);
    logic [15:0]         meas [3];
    longint              accel [4];
    longint              err;
    longint              sum;
    logic [63:0]         sq;
    logic [M_DATA_W-1:0] res;
    int a;
    int rot;
    meas[0] = r.meas_x;
    meas[1] = r.meas_y;
    meas[2] = r.meas_z;
    if (r.cmd_present) begin
      held_cmd_q    = {r.cmd_thrust, r.cmd_z, r.cmd_y, r.cmd_x};
      ctrl_active_q = 1'b1;
    end
    res = '0;
    if (ctrl_active_q) begin
      for (a = 0; a < 3; a++) begin
        err = longint'($signed(meas[a])) - longint'($signed(held_cmd_q[16*a +: 16]));
        accel[a] = -(err * longint'(gains_q[16*a +: 16]));
      end
      accel[3] = longint'(held_cmd_q[63:48]) * 1024;
      for (rot = 0; rot < MAX_ROTORS; rot++) begin
        if (rot < NUM_ROTORS_D) begin
          sum = 0;
          for (a = 0; a < 4; a++)
            sum += accel[a] * longint'($signed(mix_q[rot][16*a +: 16]));
          if (sum <= 0) begin
            sq = '0;
          end else begin
            sq = sum >>> FRAC_SH;
            if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
          end
          res[16*rot +: 16] = int_sqrt(sq[31:0]);
        end
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] pick_lane();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom_range(0, 2047)) - 16'd1024;
      1: begin
        case ($urandom_range(0, 3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // About half the requests measure rates close to the current command, so their
  // speeds stay in a useful range instead of clamping or pinning high.
  function automatic rate_req_t random_req();
    rate_req_t r;
    r.cmd_present = ($urandom_range(0, 3) == 0);
    r.cmd_x       = pick_lane();
    r.cmd_y       = pick_lane();
    r.cmd_z       = pick_lane();
    r.cmd_thrust  = pick_lane();
    if (r.cmd_present) gen_cmd = r;
    if ($urandom_range(0, 1) == 1) begin
      r.meas_x = gen_cmd.cmd_x + 16'($urandom_range(0, 511)) - 16'd256;
      r.meas_y = gen_cmd.cmd_y + 16'($urandom_range(0, 511)) - 16'd256;
      r.meas_z = gen_cmd.cmd_z + 16'($urandom_range(0, 511)) - 16'd256;
    end else begin
      r.meas_x = pick_lane();
      r.meas_y = pick_lane();
      r.meas_z = pick_lane();
    end
    return r;
  endfunction

  task automatic queue_req(input logic [15:0] mx, input logic [15:0] my,
                           input logic [15:0] mz, input logic cp,
                           input logic [15:0] cx, input logic [15:0] cy,
                           input logic [15:0] cz, input logic [15:0] th);
    rate_req_t r;
    r = {th, cz, cy, cx, cp, mz, my, mx};
    pend_reqs.push_back(r);
    n_pushed++;
  endtask

  task automatic settle();
    while (n_accepted != n_pushed || exp_speeds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_RATE_GAINS)
      gains_q = val[GAINS_W-1:0];
    else if (int'(idx) >= int'(CFG_MIX_ROW_0) && int'(idx) < int'(CFG_MIX_ROW_0) + MAX_ROTORS)
      mix_q[int'(idx) - int'(CFG_MIX_ROW_0)] = val;
  endtask

  // The gains word carries junk above bit 47, and the unused index gets a
  // write that must leave every register alone.
  task automatic apply_setting();
    int r;
    settle();
    write_reg(CFG_RATE_GAINS, {16'($urandom), next_gains});
    for (r = 0; r < MAX_ROTORS; r++)
      write_reg(CFG_MIX_ROW_0 + CFG_IDX_W'(r), next_rows[r]);
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_in = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        exp_speeds.push_back(predict_speeds(cur_req));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_in > 0) begin
          gap_in--;
          s_tvalid <= 1'b0;
        end else if (pend_reqs.size() != 0) begin
          cur_req = pend_reqs.pop_front();
          s_tdata  <= {cur_req.cmd_thrust, cur_req.cmd_z, cur_req.cmd_y, cur_req.cmd_x,
                       cur_req.meas_z, cur_req.meas_y, cur_req.meas_x};
          s_tuser  <= cur_req.cmd_present;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) gap_in = $urandom_range(1, 14);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (exp_speeds.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = exp_speeds.pop_front();
          for (k = 0; k < MAX_ROTORS; k++) begin
            if (m_tdata[16*k +: 16] !== want[16*k +: 16]) begin
              $display("%0t: rotor_speed_%0d expected %0d, actual %0d",
                       $time, k, want[16*k +: 16], m_tdata[16*k +: 16]);
              errors++;
            end
          end
        end
      end
      if (!long_stall_done && n_accepted >= 400) begin
        long_stall_done = 1'b1;
        stall_out = LONG_STALL;
      end
      if (stall_out > 0) begin
        stall_out--;
        m_tready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap_out = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    for (k = 0; k < MAX_ROTORS; k++) mix_q[k] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // No command yet: speeds stay zero and the command fields are ignored.
    queue_req(16'h7FFF, 16'h8000, 16'h0000, 1'b0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
    queue_req(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    next_gains   = {16'h0100, 16'h0300, 16'h0200};
    next_rows[0] = {16'h1000, 16'h0400, 16'h0600, 16'h0800};
    next_rows[1] = {16'h1000, 16'hFC00, 16'h0600, 16'hF800};
    next_rows[2] = {16'h1000, 16'h0400, 16'hFA00, 16'h0800};
    next_rows[3] = {16'h1000, 16'hFC00, 16'hFA00, 16'hF800};
    next_rows[4] = {16'h1000, 16'h0400, 16'h0000, 16'h7FFF};
    next_rows[5] = {16'h1000, 16'hFC00, 16'h0000, 16'h8000};
    apply_setting();
    // The first command is used by the same request that brings it.
    queue_req(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
    queue_req(16'h0100, 16'hFF00, 16'h0040, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h8000, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    queue_req(16'h7FFF, 16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'h0000);
    queue_req(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    queue_req(16'h0010, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    next_gains   = {16'hFFFF, 16'hFFFF, 16'hFFFF};
    next_rows[0] = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
    next_rows[1] = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
    next_rows[2] = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    next_rows[3] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    next_rows[4] = '0;
    next_rows[5] = {16'h7FFF, 16'h0000, 16'h0000, 16'h0000};
    apply_setting();
    queue_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF);
    queue_req(16'h8000, 16'h8000, 16'h8000, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
    queue_req(16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h8000);

    next_gains = '0;
    for (k = 0; k < MAX_ROTORS; k++) next_rows[k] = '0;
    apply_setting();
    queue_req(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_req(16'h8000, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        next_gains = {16'hFFFF, 16'hFFFF, 16'hFFFF};
        for (k = 0; k < MAX_ROTORS; k++) next_rows[k] = {4{16'h7FFF}};
      end else if (ph == 1) begin
        next_gains = {16'h0001, 16'h0001, 16'h0001};
        for (k = 0; k < MAX_ROTORS; k++) next_rows[k] = {4{16'h8000}};
      end else begin
        next_gains = {pick_lane(), pick_lane(), pick_lane()};
        for (k = 0; k < MAX_ROTORS; k++)
          next_rows[k] = {pick_lane(), pick_lane(), pick_lane(), pick_lane()};
      end
      apply_setting();
      if (ph == 5) calm = 1'b1;
      repeat (PHASE_REQS) begin
        pend_reqs.push_back(random_req());
        n_pushed++;
      end
    end

    settle();
    repeat (200) @(posedge clk);
    if (errors == 0 && exp_speeds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
